// File: design/dtoi_pkg.sv
package dtoi_pkg;

  // ascii codes the parser looks for
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  // fixed field widths
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned VALUE_W = 64;

  // where the parser stands within one string
  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_OPEN   = 2'd1,
    PH_SIGNED = 2'd2,
    PH_DIGITS = 2'd3
  } phase_t;

  // one input beat as held in the input register
  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              has_char;
    logic              last;
    logic [MODE_W-1:0] mode;
  } item_t;

  // one result beat
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               status;
  } res_t;

endpackage

// File: design/dtoi_in_if.sv
interface dtoi_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       has_char;
  logic       last;
  logic [2:0] mode;

  modport source(output valid, output character, output has_char, output last,
                 output mode, input ready);
  modport sink(input valid, input character, input has_char, input last,
               input mode, output ready);
endinterface

// File: design/dtoi_out_if.sv
interface dtoi_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic        status;

  modport source(output valid, output value, output status, input ready);
  modport sink(input valid, input value, input status, output ready);
endinterface

// File: design/dtoi_core.sv
module dtoi_core #(
  parameter int MAX_WIDTH = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            item_valid,
  input  dtoi_pkg::item_t item,
  output logic            item_take,
  output logic            res_valid,
  input  logic            res_ready,
  output dtoi_pkg::res_t  res
);

  localparam int MAXW = (MAX_WIDTH < 8) ? 8 : ((MAX_WIDTH > 64) ? 64 : MAX_WIDTH);

  dtoi_pkg::phase_t  phase_r, phase_nxt;
  logic [63:0]       mag_r, mag_nxt;
  logic [63:0]       sval_r, sval_nxt;
  logic              neg_r, neg_nxt;
  logic              fail_r, fail_nxt;
  logic [2:0]        fmt_r, fmt_nxt;
  logic              ov_r, ov_nxt;
  dtoi_pkg::res_t    res_r, res_nxt;

  // effective state for this beat (a new string starts clean)
  logic              start;
  dtoi_pkg::phase_t  ph_c;
  logic [63:0]       mag_c, sval_c;
  logic              neg_c, fail_c;
  logic [2:0]        fmt_c;

  logic              is_digit;
  logic [3:0]        dig;
  logic [6:0]        tgt_w, w;
  logic [63:0]       lim;
  logic [67:0]       prod;
  logic              ovf;
  logic [63:0]       sval_step;
  logic              bad;

  assign item_take = item_valid && (!ov_r || res_ready);
  assign res_valid = ov_r;
  assign res       = res_r;

  always_comb begin
    start  = (phase_r == dtoi_pkg::PH_START);
    ph_c   = start ? dtoi_pkg::PH_OPEN : phase_r;
    mag_c  = start ? 64'd0 : mag_r;
    sval_c = start ? 64'd0 : sval_r;
    neg_c  = start ? 1'b0 : neg_r;
    fail_c = start ? 1'b0 : fail_r;
    fmt_c  = start ? item.mode : fmt_r;
  end

  // digit decode and range limit of the target
  always_comb begin
    is_digit = item.has_char && (item.character >= dtoi_pkg::CHAR_ZERO)
               && (item.character <= dtoi_pkg::CHAR_NINE);
    dig      = 4'(item.character - dtoi_pkg::CHAR_ZERO);
    tgt_w    = 7'd8 << fmt_c[1:0];
    w        = (tgt_w > 7'(MAXW)) ? 7'(MAXW) : tgt_w;
    if (fmt_c[2]) begin
      lim = (64'd1 << (w - 7'd1)) - {63'd0, !neg_c};
    end else begin
      lim = {64{1'b1}} >> (7'd64 - w);
    end
  end

  // times ten plus digit, checked against the limit before it is taken
  always_comb begin
    prod      = ({4'd0, mag_c} << 3) + ({4'd0, mag_c} << 1) + {64'd0, dig};
    ovf       = prod > {4'd0, lim};
    sval_step = neg_c ? ((sval_c << 3) + (sval_c << 1) - {60'd0, dig})
                      : ((sval_c << 3) + (sval_c << 1) + {60'd0, dig});
  end

  // next state and result
  always_comb begin
    phase_nxt = phase_r;
    mag_nxt   = mag_r;
    sval_nxt  = sval_r;
    neg_nxt   = neg_r;
    fail_nxt  = fail_r;
    fmt_nxt   = fmt_r;
    ov_nxt    = ov_r && !res_ready;
    res_nxt   = res_r;
    bad       = 1'b0;
    if (item_take) begin
      phase_nxt = ph_c;
      mag_nxt   = mag_c;
      sval_nxt  = sval_c;
      neg_nxt   = neg_c;
      fail_nxt  = fail_c;
      fmt_nxt   = fmt_c;
      if (item.has_char) begin
        if (is_digit) begin
          phase_nxt = dtoi_pkg::PH_DIGITS;
          if (!fail_c) begin
            if (ovf) begin
              fail_nxt = 1'b1;
            end else begin
              mag_nxt  = prod[63:0];
              sval_nxt = sval_step;
            end
          end
        end else if (ph_c == dtoi_pkg::PH_OPEN && item.character == dtoi_pkg::CHAR_PLUS) begin
          phase_nxt = dtoi_pkg::PH_SIGNED;
        end else if (ph_c == dtoi_pkg::PH_OPEN && item.character == dtoi_pkg::CHAR_MINUS
                     && fmt_c[2]) begin
          neg_nxt   = 1'b1;
          phase_nxt = dtoi_pkg::PH_SIGNED;
        end else begin
          fail_nxt = 1'b1;
        end
      end
      if (item.last) begin
        bad            = fail_nxt || (phase_nxt != dtoi_pkg::PH_DIGITS);
        ov_nxt         = 1'b1;
        res_nxt.status = bad;
        res_nxt.value  = bad ? 64'd0 : sval_nxt;
        phase_nxt      = dtoi_pkg::PH_START;
        mag_nxt        = 64'd0;
        sval_nxt       = 64'd0;
        neg_nxt        = 1'b0;
        fail_nxt       = 1'b0;
      end
    end
  end

  // control and accumulator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= dtoi_pkg::PH_START;
      mag_r   <= 64'd0;
      sval_r  <= 64'd0;
      neg_r   <= 1'b0;
      fail_r  <= 1'b0;
      fmt_r   <= 3'd0;
      ov_r    <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      mag_r   <= mag_nxt;
      sval_r  <= sval_nxt;
      neg_r   <= neg_nxt;
      fail_r  <= fail_nxt;
      fmt_r   <= fmt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  // a string's last beat always returns the parser to the start
  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (item_take && item.last) |=> (phase_r == dtoi_pkg::PH_START))
    else $error("parser did not restart after last beat");

  // failed results carry a zero value
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && res_r.status) |-> (res_r.value == 64'd0))
    else $error("failed result with nonzero value");

  // signed accumulator tracks the magnitude and sign
  a_sval_match: assert property (@(posedge clk) disable iff (!rst_n)
    !fail_r |-> (sval_r == (neg_r ? (~mag_r + 64'd1) : mag_r)))
    else $error("signed accumulator out of step with magnitude");

  // an 8-bit unsigned target never holds more than 8 bits
  a_u8_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != dtoi_pkg::PH_START && fmt_r == 3'd0) |-> (mag_r[63:8] == 56'd0))
    else $error("8-bit magnitude exceeded its range");

endmodule

// File: design/decimal_text_to_integer_top.sv
// Decimal text to integer converter with range check.
// in_chan takes one text byte per beat (valid/ready); mode on the first beat
// of a string picks the target: 0-3 unsigned 8/16/32/64, 4-7 signed.
// A beat with has_char low carries no byte; with last high it ends an empty
// string. Only legal: an optional sign (- if signed), then one or more digits.
// out_chan gives one beat per string, on its last byte: value (sign-extended
// two's complement for signed targets) and status (1 = failed, value zero).
// Throughput: one byte per cycle while out_chan is not stalled. Each byte
// passes an input register and then one times-ten add and limit compare into
// the accumulator; a string's last byte also loads the result register.
// When out_chan stalls, the result holds; one more byte may wait in the
// input register, and in_chan.ready drops only when both are occupied.
// Reset (rst_n low, synchronous) empties both registers and puts the parser
// at the start of a string.
module decimal_text_to_integer_top #(
  parameter int MAX_WIDTH = 64
) (
  input logic        clk,
  input logic        rst_n,
  dtoi_in_if.sink    in_chan,
  dtoi_out_if.source out_chan
);

  logic            iv_r, iv_nxt;
  dtoi_pkg::item_t item_r;
  logic            take;
  logic            in_fire;
  dtoi_pkg::res_t  res;

  assign in_chan.ready = !iv_r || take;
  assign in_fire       = in_chan.valid && in_chan.ready;

  // input register
  always_comb begin
    iv_nxt = iv_r;
    if (in_fire) begin
      iv_nxt = 1'b1;
    end else if (take) begin
      iv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
    end else begin
      iv_r <= iv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.character <= in_chan.character;
      item_r.has_char  <= in_chan.has_char;
      item_r.last      <= in_chan.last;
      item_r.mode      <= in_chan.mode;
    end
  end

  // parser and result register
  dtoi_core #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (iv_r),
    .item       (item_r),
    .item_take  (take),
    .res_valid  (out_chan.valid),
    .res_ready  (out_chan.ready),
    .res        (res)
  );

  assign out_chan.value  = res.value;
  assign out_chan.status = res.status;

endmodule
